[rtl/core/fbr_pkg.sv]
// Shared types and constants for the flash bad-block remapper.
`timescale 1ns / 1ps

package fbr_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 64;
  localparam int unsigned SEG_BYTES_DEF  = 512;   // power of two

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned VA_W     = 15;
  localparam int unsigned PB_OUT_W = 6;
  localparam int unsigned WEAR_W   = 20;

  localparam logic [WEAR_W-1:0] WEAR_MAX        = '1;
  localparam logic [WEAR_W-1:0] ERASE_LIMIT_RST = 20'd100000;

  // register index = paddr[2]
  localparam logic REG_DISK_BASE   = 1'b0;
  localparam logic REG_ERASE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    FN_TRANSLATE = 2'd0,
    FN_ERASE_REQ = 2'd1,
    FN_ERASE_OUT = 2'd2,
    FN_WRITE_OUT = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_TRANSLATED  = 3'd0,
    ST_ISSUE_ERASE = 3'd1,
    ST_ERASE_DONE  = 3'd2,
    ST_NO_SPACE    = 3'd3,
    ST_WRITE_OK    = 3'd4,
    ST_REMAPPED    = 3'd5,
    ST_IGNORED     = 3'd6,
    ST_BAD_ADDR    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    BLK_FREE    = 2'd0,
    BLK_INUSE   = 2'd1,
    BLK_RETIRED = 2'd2
  } blk_state_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD_TAB,
    S_TAB,
    S_RD_WEAR,
    S_WEAR,
    S_RETIRE,
    S_SCAN_RD,
    S_SCAN,
    S_CLAIM,
    S_RD_INC,
    S_INC,
    S_FINISH
  } seq_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] disk_base;
    logic [WEAR_W-1:0] erase_limit;
  } cfg_t;

endpackage

[rtl/core/fbr_core.sv]
// Remap sequencer: block map, block status and wear memories, scan and shared adder.
`timescale 1ns / 1ps

module fbr_core #(
  parameter int unsigned NUM_BLOCKS = fbr_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SEG_BYTES  = fbr_pkg::SEG_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fbr_pkg::cfg_t                   cfg_i,
  input  logic                            start_i,
  input  logic [1:0]                      func_i,
  input  logic [fbr_pkg::VA_W-1:0]        virt_addr_i,
  input  logic                            ok_i,
  output logic                            busy_o,
  output logic                            done_o,
  output fbr_pkg::status_e                status_o,
  output logic [fbr_pkg::ADDR_W-1:0]      phys_addr_o,
  output logic [fbr_pkg::PB_OUT_W-1:0]    phys_block_o,
  output logic                            no_space_o
);

  import fbr_pkg::*;

  localparam int unsigned BW    = $clog2(NUM_BLOCKS);
  localparam int unsigned SEG_W = $clog2(SEG_BYTES);

  seq_state_e state_q, state_d;

  func_e              func_q, func_d;
  logic [VA_W-1:0]    va_q, va_d;
  logic               ok_q, ok_d;
  logic [BW-1:0]      pb_q, pb_d;
  logic [BW-1:0]      rvb_q, rvb_d;
  logic [BW:0]        scan_q, scan_d;
  logic [BW:0]        free_q, free_d;
  logic               pend_q, pend_d;
  logic [BW-1:0]      pvb_q, pvb_d;
  logic [BW-1:0]      ppb_q, ppb_d;
  logic               nospace_q, nospace_d;
  logic [BW-1:0]      clr_q, clr_d;
  status_e            res_q, res_d;
  logic               have_q, have_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [ADDR_W-1:0]  paddr_q, paddr_d;
  logic [PB_OUT_W-1:0] pblk_q, pblk_d;

  // memories
  logic [BW-1:0]     tab_mem [NUM_BLOCKS];
  blk_state_e        st_mem  [NUM_BLOCKS];
  logic [WEAR_W-1:0] wear_mem[NUM_BLOCKS];

  logic              tab_we, st_we, wear_we;
  logic [BW-1:0]     tab_waddr, st_waddr, wear_waddr;
  logic [BW-1:0]     tab_wdata;
  blk_state_e        st_wdata;
  logic [WEAR_W-1:0] wear_wdata;
  logic [BW-1:0]     tab_raddr, st_raddr, wear_raddr;
  logic [BW-1:0]     tab_rdata;
  blk_state_e        st_rdata;
  logic [WEAR_W-1:0] wear_rdata;

  // address decode
  logic [ADDR_W-1:0] va_ext, vb_full, off_full, blk_off;
  logic              bad_addr;
  logic [BW-1:0]     vb_idx;
  logic              scan_end, worn;

  // shared adder
  logic [ADDR_W-1:0] add_a, add_b, add_sum;

  assign va_ext   = ADDR_W'(va_q);
  assign vb_full  = va_ext >> SEG_W;
  assign off_full = va_ext & (ADDR_W'(SEG_BYTES) - ADDR_W'(1));
  assign blk_off  = ADDR_W'(pb_q) << SEG_W;
  assign bad_addr = (func_q != FN_ERASE_OUT) && (vb_full >= ADDR_W'(NUM_BLOCKS));
  assign vb_idx   = vb_full[BW-1:0];
  assign scan_end = (scan_q == (BW+1)'(NUM_BLOCKS));
  assign worn     = (wear_rdata >= cfg_i.erase_limit);

  assign tab_raddr  = vb_idx;
  assign st_raddr   = scan_q[BW-1:0];
  assign wear_raddr = pb_q;

  always_comb begin
    case (state_q)
      S_SCAN: begin
        add_a = ADDR_W'(scan_q);
        add_b = ADDR_W'(1);
      end
      S_INC: begin
        add_a = ADDR_W'(wear_rdata);
        add_b = ADDR_W'(1);
      end
      default: begin
        add_a = cfg_i.disk_base;
        add_b = blk_off | ((func_q == FN_TRANSLATE) ? off_full : '0);
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (clr_q == BW'(NUM_BLOCKS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) state_d = S_RD_TAB;
      end
      S_RD_TAB: state_d = S_TAB;
      S_TAB: begin
        if (bad_addr) begin
          state_d = S_FINISH;
        end else begin
          case (func_q)
            FN_TRANSLATE: state_d = S_FINISH;
            FN_ERASE_REQ: state_d = S_RD_WEAR;
            FN_ERASE_OUT: state_d = !pend_q ? S_FINISH : (ok_q ? S_RD_INC : S_RETIRE);
            default:      state_d = ok_q ? S_FINISH : S_RETIRE;
          endcase
        end
      end
      S_RD_WEAR: state_d = S_WEAR;
      S_WEAR:    state_d = worn ? S_RETIRE : S_FINISH;
      S_RETIRE:  state_d = S_SCAN_RD;
      S_SCAN_RD: state_d = scan_end ? S_FINISH : S_SCAN;
      S_SCAN:    state_d = (st_rdata == BLK_FREE) ? S_CLAIM : S_SCAN_RD;
      S_CLAIM:   state_d = (func_q == FN_WRITE_OUT) ? S_FINISH : S_RD_WEAR;
      S_RD_INC:  state_d = S_INC;
      S_INC:     state_d = S_FINISH;
      S_FINISH:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    func_d    = func_q;
    va_d      = va_q;
    ok_d      = ok_q;
    pb_d      = pb_q;
    rvb_d     = rvb_q;
    scan_d    = scan_q;
    free_d    = free_q;
    pend_d    = pend_q;
    pvb_d     = pvb_q;
    ppb_d     = ppb_q;
    nospace_d = nospace_q;
    clr_d     = clr_q;
    res_d     = res_q;
    have_d    = have_q;
    done_d    = 1'b0;
    status_d  = status_q;
    paddr_d   = paddr_q;
    pblk_d    = pblk_q;

    tab_we     = 1'b0;
    tab_waddr  = rvb_q;
    tab_wdata  = scan_q[BW-1:0];
    st_we      = 1'b0;
    st_waddr   = pb_q;
    st_wdata   = BLK_INUSE;
    wear_we    = 1'b0;
    wear_waddr = pb_q;
    wear_wdata = (wear_rdata == WEAR_MAX) ? wear_rdata : add_sum[WEAR_W-1:0];

    case (state_q)
      S_INIT: begin
        tab_we     = 1'b1;
        tab_waddr  = clr_q;
        tab_wdata  = clr_q;
        st_we      = 1'b1;
        st_waddr   = clr_q;
        st_wdata   = BLK_FREE;
        wear_we    = 1'b1;
        wear_waddr = clr_q;
        wear_wdata = '0;
        clr_d      = clr_q + BW'(1);
      end
      S_IDLE: begin
        if (start_i) begin
          func_d = func_e'(func_i);
          va_d   = virt_addr_i;
          ok_d   = ok_i;
        end
      end
      S_TAB: begin
        have_d = 1'b0;
        if (bad_addr) begin
          res_d = ST_BAD_ADDR;
        end else begin
          case (func_q)
            FN_TRANSLATE: begin
              pb_d   = tab_rdata;
              res_d  = ST_TRANSLATED;
              have_d = 1'b1;
            end
            FN_ERASE_REQ: begin
              pb_d  = tab_rdata;
              rvb_d = vb_idx;
            end
            FN_ERASE_OUT: begin
              res_d = ST_IGNORED;
              pb_d  = ppb_q;
              rvb_d = pvb_q;
            end
            default: begin
              pb_d  = tab_rdata;
              rvb_d = vb_idx;
              if (ok_q) begin
                st_we    = 1'b1;
                st_waddr = tab_rdata;
                st_wdata = BLK_INUSE;
                res_d    = ST_WRITE_OK;
                have_d   = 1'b1;
              end
            end
          endcase
        end
      end
      S_WEAR: begin
        if (!worn) begin
          pend_d = 1'b1;
          pvb_d  = rvb_q;
          ppb_d  = pb_q;
          res_d  = ST_ISSUE_ERASE;
          have_d = 1'b1;
        end
      end
      S_RETIRE: begin
        st_we    = 1'b1;
        st_wdata = BLK_RETIRED;
        scan_d   = free_q;
      end
      S_SCAN_RD: begin
        if (scan_end) begin
          free_d    = scan_q;
          nospace_d = 1'b1;
          res_d     = ST_NO_SPACE;
          have_d    = 1'b0;
          if (func_q != FN_WRITE_OUT) pend_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (st_rdata == BLK_FREE) begin
          free_d = scan_q;
        end else begin
          scan_d = add_sum[BW:0];
        end
      end
      S_CLAIM: begin
        st_we    = 1'b1;
        st_waddr = scan_q[BW-1:0];
        st_wdata = BLK_INUSE;
        tab_we   = 1'b1;
        pb_d     = scan_q[BW-1:0];
        if (func_q == FN_WRITE_OUT) begin
          res_d  = ST_REMAPPED;
          have_d = 1'b1;
        end
      end
      S_INC: begin
        wear_we  = 1'b1;
        st_we    = 1'b1;
        st_wdata = BLK_INUSE;
        pend_d   = 1'b0;
        res_d    = ST_ERASE_DONE;
        have_d   = 1'b1;
      end
      S_FINISH: begin
        done_d   = 1'b1;
        status_d = res_q;
        paddr_d  = have_q ? add_sum : '0;
        pblk_d   = have_q ? PB_OUT_W'(pb_q) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      scan_q    <= '0;
      free_q    <= '0;
      pend_q    <= 1'b0;
      pvb_q     <= '0;
      ppb_q     <= '0;
      nospace_q <= 1'b0;
      clr_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      scan_q    <= scan_d;
      free_q    <= free_d;
      pend_q    <= pend_d;
      pvb_q     <= pvb_d;
      ppb_q     <= ppb_d;
      nospace_q <= nospace_d;
      clr_q     <= clr_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    va_q     <= va_d;
    ok_q     <= ok_d;
    pb_q     <= pb_d;
    rvb_q    <= rvb_d;
    res_q    <= res_d;
    have_q   <= have_d;
    status_q <= status_d;
    paddr_q  <= paddr_d;
    pblk_q   <= pblk_d;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    tab_rdata <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rdata <= st_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wear_we) wear_mem[wear_waddr] <= wear_wdata;
    wear_rdata <= wear_mem[wear_raddr];
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign phys_addr_o  = paddr_q;
  assign phys_block_o = pblk_q;
  assign no_space_o   = nospace_q;

  // an accepted beat leaves idle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not start the sequencer");

  // strobe only follows the finish step
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FINISH))
    else $error("result strobe without finish step");

  // no-space flag is sticky
  a_nospace_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nospace_q |=> nospace_q)
    else $error("no-space flag dropped");

  // unused blocks only shrink, so the free pointer never moves back
  a_free_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> free_q >= $past(free_q))
    else $error("free pointer moved back");

  // an issued erase leaves a pending erase behind
  a_issue_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_ISSUE_ERASE |-> pend_q)
    else $error("erase issued without pending record");

endmodule

[rtl/core/flash_bad_block_remapper.sv]
// Top level: flash bad-block remapper with APB configuration registers.
`timescale 1ns / 1ps

// Sequence: a beat reads the block map, then finishes for a translate or a write success;
//   each wear check adds its own read, an erase success a wear update, and a remap the
//   retire and claim plus a status scan from the first-free pointer.
// Beats: the block takes no new beat until the last one has finished; status scans set
//   the worst case. Results are strobed for one cycle and the receiver cannot stall them.
// Reset: a clearing pass over all NUM_BLOCKS entries after rst_ni rises; busy_o stays high.
module flash_bad_block_remapper #(
  parameter int unsigned NUM_BLOCKS = fbr_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned SEG_BYTES  = fbr_pkg::SEG_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // command beat
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    func_i,
  input  logic [fbr_pkg::VA_W-1:0]      virt_addr_i,
  input  logic                          ok_i,
  // result beat
  output logic                          done_o,
  output logic [2:0]                    status_o,
  output logic [fbr_pkg::ADDR_W-1:0]    phys_addr_o,
  output logic [fbr_pkg::PB_OUT_W-1:0]  phys_block_o,
  output logic                          no_space_o
);

  import fbr_pkg::*;

  logic [ADDR_W-1:0] disk_base_q, disk_base_d;
  logic [WEAR_W-1:0] erase_limit_q, erase_limit_d;
  logic              apb_wr;
  cfg_t              cfg;
  status_e           status;

  // write lands on the access phase; no wait states
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_comb begin
    disk_base_d   = disk_base_q;
    erase_limit_d = erase_limit_q;
    if (apb_wr) begin
      case (paddr[2])
        REG_DISK_BASE:   disk_base_d   = pwdata;
        REG_ERASE_LIMIT: erase_limit_d = pwdata[WEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_base_q   <= '0;
      erase_limit_q <= ERASE_LIMIT_RST;
    end else begin
      disk_base_q   <= disk_base_d;
      erase_limit_q <= erase_limit_d;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_DISK_BASE:   prdata = disk_base_q;
      REG_ERASE_LIMIT: prdata = 32'(erase_limit_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg.disk_base   = disk_base_q;
  assign cfg.erase_limit = erase_limit_q;

  // sequencer, memories and scan
  fbr_core #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SEG_BYTES  (SEG_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start_i      (start_i),
    .func_i       (func_i),
    .virt_addr_i  (virt_addr_i),
    .ok_i         (ok_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .status_o     (status),
    .phys_addr_o  (phys_addr_o),
    .phys_block_o (phys_block_o),
    .no_space_o   (no_space_o)
  );

  assign status_o = status;

endmodule

[verif/flash_bad_block_remapper_tb.sv]
// Self-checking testbench for the flash bad-block remapper: APB setup, command beats, scoreboard.
`timescale 1ns / 1ps

module flash_bad_block_remapper_tb;
  import fbr_pkg::*;

  localparam int unsigned NUM_BLK     = NUM_BLOCKS_DEF;
  localparam int unsigned SEG         = SEG_BYTES_DEF;
  // Generous: well above the slowest legal run (full status scans on every remap, sender
  // gaps).
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  // One result beat as the block reports it.
  typedef struct packed {
    status_e                status;
    logic [ADDR_W-1:0]      phys_addr;
    logic [PB_OUT_W-1:0]    phys_block;
    logic                   no_space;
  } remap_result_t;

  // Mirror of the map, status and wear memories plus the pending erase; works out
  // the result of every accepted command beat and checks the strobed results in order.
  class remap_scoreboard;
    logic [ADDR_W-1:0]   disk_base;
    logic [WEAR_W-1:0]   erase_limit;
    logic [5:0]          map_tab [NUM_BLK];
    blk_state_e          blk_st [NUM_BLK];
    logic [WEAR_W-1:0]   wear [NUM_BLK];
    bit                  erase_pend;
    logic [5:0]          pend_vb;
    logic [5:0]          pend_pb;
    bit                  exhausted;
    remap_result_t       expected_q [$];
    int unsigned         errors;

    function new();
      disk_base   = '0;
      erase_limit = ERASE_LIMIT_RST;
      for (int i = 0; i < NUM_BLK; i++) begin
        map_tab[i] = 6'(i);
        blk_st[i]  = BLK_FREE;
        wear[i]    = '0;
      end
      erase_pend = 1'b0;
      pend_vb    = '0;
      pend_pb    = '0;
      exhausted  = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == REG_DISK_BASE) begin
        disk_base = val;
      end else begin
        erase_limit = val[WEAR_W-1:0];
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Lowest unused block is claimed as used.
    function bit claim_free(output logic [5:0] pb);
      pb = '0;
      for (int i = 0; i < NUM_BLK; i++) begin
        if (blk_st[i] == BLK_FREE) begin
          blk_st[i] = BLK_INUSE;
          pb = 6'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit retire_remap(logic [5:0] vb, inout logic [5:0] pb);
      logic [5:0] nb;
      blk_st[pb] = BLK_RETIRED;
      if (!claim_free(nb)) begin
        exhausted = 1'b1;
        return 1'b0;
      end
      map_tab[vb] = nb;
      pb = nb;
      return 1'b1;
    endfunction

    // Worn blocks are retired until one is usable; then the erase is armed, unless none is left.
    function status_e start_block_erase(logic [5:0] vb, logic [5:0] pb_in,
                                        output logic [5:0] pb_out);
      logic [5:0] pb;
      pb     = pb_in;
      pb_out = '0;
      while (wear[pb] >= erase_limit) begin
        if (!retire_remap(vb, pb)) begin
          erase_pend = 1'b0;
          return ST_NO_SPACE;
        end
      end
      erase_pend = 1'b1;
      pend_vb    = vb;
      pend_pb    = pb;
      pb_out     = pb;
      return ST_ISSUE_ERASE;
    endfunction

    function void note_beat(func_e fn, logic [VA_W-1:0] va, logic ok);
      int unsigned    vb;
      int unsigned    off;
      logic [5:0]     pb;
      logic [5:0]     cur;
      status_e        st;
      bit             have_blk;
      remap_result_t  r;
      vb       = va / SEG;
      off      = va % SEG;
      st       = ST_IGNORED;
      pb       = '0;
      have_blk = 1'b0;
      if (fn != FN_ERASE_OUT && vb >= NUM_BLK) begin
        st = ST_BAD_ADDR;
      end else begin
        case (fn)
          FN_TRANSLATE: begin
            pb       = map_tab[vb];
            st       = ST_TRANSLATED;
            have_blk = 1'b1;
          end
          FN_ERASE_REQ: begin
            st       = start_block_erase(6'(vb), map_tab[vb], pb);
            have_blk = (st == ST_ISSUE_ERASE);
          end
          FN_ERASE_OUT: begin
            if (erase_pend) begin
              cur = pend_pb;
              if (ok) begin
                if (wear[cur] != WEAR_MAX) wear[cur] = wear[cur] + 1'b1;
                blk_st[cur] = BLK_INUSE;
                erase_pend  = 1'b0;
                pb          = cur;
                st          = ST_ERASE_DONE;
                have_blk    = 1'b1;
              end else if (!retire_remap(pend_vb, cur)) begin
                erase_pend = 1'b0;
                st         = ST_NO_SPACE;
              end else begin
                st       = start_block_erase(pend_vb, cur, pb);
                have_blk = (st == ST_ISSUE_ERASE);
              end
            end
          end
          default: begin
            pb = map_tab[vb];
            if (ok) begin
              blk_st[pb] = BLK_INUSE;
              st         = ST_WRITE_OK;
              have_blk   = 1'b1;
            end else if (retire_remap(6'(vb), pb)) begin
              st       = ST_REMAPPED;
              have_blk = 1'b1;
            end else begin
              st = ST_NO_SPACE;
            end
          end
        endcase
      end
      r.status   = st;
      r.no_space = exhausted;
      if (!have_blk) begin
        r.phys_block = '0;
        r.phys_addr  = '0;
      end else begin
        r.phys_block = pb;
        r.phys_addr  = disk_base + 32'(pb) * 32'(SEG) +
                       ((st == ST_TRANSLATED) ? 32'(off) : 32'd0);
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(remap_result_t got);
      remap_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status %0d addr %h blk %0d ns %0b",
                   got.status, got.phys_addr, got.phys_block, got.no_space);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.phys_addr !== exp.phys_addr ||
          got.phys_block !== exp.phys_block || got.no_space !== exp.no_space) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st %0d addr %h blk %0d ns %0b / got st %0d addr %h blk %0d ns %0b",
                   exp.status, exp.phys_addr, exp.phys_block, exp.no_space,
                   got.status, got.phys_addr, got.phys_block, got.no_space);
      end
    endfunction
  endclass

  // clock, reset and every block input start at known values
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [2:0]            paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  logic [1:0]            func_i      = '0;
  logic [VA_W-1:0]       virt_addr_i = '0;
  logic                  ok_i        = 1'b0;
  logic                  done_o;
  logic [2:0]            status_o;
  logic [ADDR_W-1:0]     phys_addr_o;
  logic [PB_OUT_W-1:0]   phys_block_o;
  logic                  no_space_o;

  remap_scoreboard sb = new();
  int unsigned     idle_pct = 0;   // chance per cycle that the sender holds off
  int unsigned     beats_sent;

  always #5 clk_i = ~clk_i;

  flash_bad_block_remapper DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .virt_addr_i  (virt_addr_i),
    .ok_i         (ok_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .phys_addr_o  (phys_addr_o),
    .phys_block_o (phys_block_o),
    .no_space_o   (no_space_o)
  );

  // Result beats cannot be held off, so every strobe is checked at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result('{status_e'(status_o), phys_addr_o, phys_block_o, no_space_o});
  end

  // Hard stop should the block hang or lose a result.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("flash_bad_block_remapper_tb: FAIL");
    $finish;
  end

  // APB write: setup cycle, then access cycle; pready is tied high so the
  // register takes the value at the edge ending the access cycle. The bus then
  // idles with psel low so the next transfer starts at a later edge.
  task automatic apb_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds start high until the block takes the beat; start stays high afterwards
  // so a back-to-back beat needs no second assignment in the same step.
  task automatic send_beat(func_e fn, logic [VA_W-1:0] va, logic ok);
    start_i     <= 1'b1;
    func_i      <= fn;
    virt_addr_i <= va;
    ok_i        <= ok;
    do @(posedge clk_i); while (busy_o);
    sb.note_beat(fn, va, ok);
    beats_sent++;
  endtask

  // Random sender idling; now and then the sender also waits for every result.
  task automatic sender_gap();
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    if ($urandom_range(149) == 0) drain();
  endtask

  task automatic issue(func_e fn, logic [VA_W-1:0] va, logic ok);
    send_beat(fn, va, ok);
    sender_gap();
  endtask

  // Quiesce: nothing outstanding and the block idle, then a short settle.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.outstanding() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write traffic is kept mostly to the low virtual blocks so the upper physical
  // blocks stay unused as a spare pool for remaps.
  function automatic logic [VA_W-1:0] hot_addr();
    int unsigned r;
    int unsigned vb;
    r = $urandom_range(99);
    if (r < 85)      vb = $urandom_range(15);
    else if (r < 97) vb = $urandom_range(31, 16);
    else             vb = $urandom_range(NUM_BLK - 1);
    return VA_W'(vb * SEG + $urandom_range(SEG - 1));
  endfunction

  // Mostly well-formed traffic: translates, request/outcome erase sequences run to
  // completion, write outcomes; the rest is lone outcomes and stray requests.
  task automatic run_random(int unsigned n_items);
    int unsigned target;
    int unsigned r;
    int unsigned tries;
    target = beats_sent + n_items;
    while (beats_sent < target) begin
      r = $urandom_range(99);
      if (r < 35) begin
        issue(FN_TRANSLATE, VA_W'($urandom_range(32767)), 1'($urandom));
      end else if (r < 62) begin
        issue(FN_ERASE_REQ, hot_addr(), 1'($urandom));
        if ($urandom_range(99) < 8)
          issue(FN_TRANSLATE, VA_W'($urandom_range(32767)), 1'($urandom));
        if ($urandom_range(99) < 4) begin
          // broken sequence: outcome never reported, next request replaces it
        end else begin
          tries = 0;
          while (sb.erase_pend && tries < 6) begin
            issue(FN_ERASE_OUT, VA_W'($urandom_range(32767)), $urandom_range(99) < 95);
            tries++;
          end
        end
      end else if (r < 88) begin
        issue(FN_WRITE_OUT, hot_addr(), $urandom_range(99) < 97);
      end else if (r < 95) begin
        issue(FN_ERASE_OUT, VA_W'($urandom_range(32767)), 1'($urandom));
      end else begin
        issue(FN_ERASE_REQ, VA_W'($urandom_range(32767)), 1'($urandom));
      end
    end
  endtask

  initial begin
    beats_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass after reset keeps busy high
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // base near the top so block addresses wrap; widest wear limit
    apb_write(REG_DISK_BASE, 32'hFFFF_F000);
    apb_write(REG_ERASE_LIMIT, 32'h000F_FFFF);

    // directed: field extremes, outcome with nothing pending, replaced request,
    // failed erase with remap and reissue, write failure remap
    issue(FN_TRANSLATE, 15'h0000, 1'b0);
    issue(FN_TRANSLATE, 15'h7FFF, 1'b1);
    issue(FN_TRANSLATE, 15'h01FF, 1'b0);
    issue(FN_TRANSLATE, 15'h5A00, 1'b1);
    issue(FN_ERASE_OUT, 15'h7FFF, 1'b1);
    issue(FN_ERASE_OUT, 15'h0000, 1'b0);
    issue(FN_WRITE_OUT, 15'h0000, 1'b1);
    issue(FN_ERASE_REQ, 15'h0010, 1'b0);
    issue(FN_ERASE_REQ, 15'h0200, 1'b1);
    issue(FN_ERASE_OUT, 15'h0000, 1'b1);
    issue(FN_ERASE_OUT, 15'h0000, 1'b1);
    issue(FN_ERASE_REQ, 15'h0400, 1'b0);
    issue(FN_ERASE_OUT, 15'h0000, 1'b0);
    issue(FN_ERASE_OUT, 15'h0000, 1'b1);
    issue(FN_WRITE_OUT, 15'h0A00, 1'b0);
    issue(FN_TRANSLATE, 15'h0A55, 1'b0);
    issue(FN_TRANSLATE, 15'h0400, 1'b0);
    issue(FN_WRITE_OUT, 15'h0A00, 1'b1);
    issue(FN_WRITE_OUT, 15'h7E00, 1'b1);
    issue(FN_TRANSLATE, 15'h7E01, 1'b0);
    drain();

    // back-to-back beats, random base
    apb_write(REG_DISK_BASE, $urandom);
    run_random(400);
    drain();

    // sender mostly idle, default-sized wear limit
    idle_pct = 72;
    apb_write(REG_ERASE_LIMIT, 32'(ERASE_LIMIT_RST));
    apb_write(REG_DISK_BASE, $urandom);
    run_random(350);
    drain();

    // low wear limit so worn blocks get retired
    idle_pct = 30;
    apb_write(REG_DISK_BASE, 32'h0);
    apb_write(REG_ERASE_LIMIT, 32'($urandom_range(6, 2)));
    run_random(350);
    drain();

    // smallest legal limit: any block erased once is worn on the next request
    idle_pct = 72;
    apb_write(REG_ERASE_LIMIT, 32'd1);
    issue(FN_ERASE_REQ, 15'h0E00, 1'b0);
    issue(FN_ERASE_OUT, 15'h0000, 1'b1);
    issue(FN_ERASE_REQ, 15'h0E00, 1'b0);
    issue(FN_ERASE_OUT, 15'h0000, 1'b1);
    run_random(300);
    drain();

    // zero limit: every block is worn, one request drains the spare pool
    idle_pct = 0;
    apb_write(REG_DISK_BASE, 32'hFFFF_FFFF);
    apb_write(REG_ERASE_LIMIT, 32'd0);
    issue(FN_ERASE_REQ, 15'h0600, 1'b1);
    issue(FN_WRITE_OUT, 15'h0800, 1'b0);
    issue(FN_ERASE_OUT, 15'h0000, 1'b1);
    run_random(150);
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("flash_bad_block_remapper_tb: PASS");
    end else begin
      $display("flash_bad_block_remapper_tb: FAIL");
    end
    $finish;
  end

endmodule
